/* hw/rtl/llh_pkg.sv */
// Shared types and constants for the log-linear latency histogram.
// Beat layouts, command codes and the controller state encoding.
// No dependencies.
`default_nettype none

package llh_pkg;

  localparam int SAMPLE_W    = 64;
  localparam int FRAC_W      = 17;
  localparam int CNT_OUT_W   = 32;
  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 96;

  localparam logic [FRAC_W-1:0] Q16_ONE = 17'h10000;

  localparam logic CMD_RECORD = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_MUL   = 7'b0000100,
    ST_TGT   = 7'b0001000,
    ST_WALK  = 7'b0010000,
    ST_TOP   = 7'b0100000,
    ST_DONE  = 7'b1000000
  } llh_state_t;

endpackage

`default_nettype wire

/* hw/rtl/log_linear_latency_histogram.sv */
// Log-linear latency histogram: bucket counters in one synchronous RAM,
// record read-modify-write pipeline and percentile walk controller.
// Depends on llh_pkg.
//
//  channel | dir | tdata (low bit up)                        | tuser
//  in_     | in  | sample_value[63:0], fraction_q16[80:64]    | cmd
//  out_    | out | percentile_value[63:0], sample_count[95:64]| -
//
// Record beats: one per cycle while in_tready is high; three-stage slot / read /
// write pipeline with forwarding of the last written counter into the next
// update of that bucket. Query beats: the bucket walk reads one RAM entry per
// cycle; in_tready is low for the whole query. Reset: a clearing pass writes
// zero to all NUM_BUCKETS entries, one per cycle, with in_tready low. A finished
// result waits in the output register while a stalled out_tready holds it; the
// next query is held only at its result.
`default_nettype none

module log_linear_latency_histogram #(
  parameter int SUB_BUCKET_BITS = 5,
  parameter int NUM_OCTAVES     = 15,
  parameter int COUNT_BITS      = 32
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // sample_value[63:0], fraction_q16[80:64], zero fill
  input  wire logic [llh_pkg::IN_TDATA_W-1:0]   in_tdata,
  // cmd
  input  wire logic [0:0]                       in_tuser,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // percentile_value[63:0], sample_count[95:64]
  output logic [llh_pkg::OUT_TDATA_W-1:0]       out_tdata
);

  import llh_pkg::*;

  localparam int SUB_COUNT   = 1 << SUB_BUCKET_BITS;
  localparam int NUM_BUCKETS = (NUM_OCTAVES + 1) * SUB_COUNT;
  localparam int IDX_W       = $clog2(NUM_BUCKETS);
  localparam int PROD_W      = COUNT_BITS + FRAC_W;
  localparam int CUM_W       = COUNT_BITS + 1;

  localparam logic [COUNT_BITS-1:0] CNT_MAX  = {COUNT_BITS{1'b1}};
  localparam logic [IDX_W-1:0]      IDX_LAST = IDX_W'(NUM_BUCKETS - 1);
  localparam logic [IDX_W:0]        IDX_END  = (IDX_W + 1)'(NUM_BUCKETS);

  logic [COUNT_BITS-1:0] mem [NUM_BUCKETS];

  llh_state_t state_r, state_nxt;

  logic                  in_acc;
  logic [SAMPLE_W-1:0]   in_sample;
  logic [FRAC_W-1:0]     in_frac;

  logic [COUNT_BITS-1:0] total_r;
  logic [SAMPLE_W-1:0]   largest_r;
  logic [FRAC_W-1:0]     frac_r;

  logic                  rec_a_vld_r;
  logic [SAMPLE_W-1:0]   rec_a_val_r;
  logic                  rec_b_vld_r;
  logic [IDX_W-1:0]      rec_b_idx_r;
  logic                  rec_c_vld_r;
  logic [IDX_W-1:0]      rec_c_idx_r;
  logic                  wl_vld_r;
  logic [IDX_W-1:0]      wl_idx_r;
  logic [COUNT_BITS-1:0] wl_val_r;

  logic [5:0]            msb;
  logic [6:0]            oct;
  logic [5:0]            sh;
  logic [SAMPLE_W-1:0]   shifted;
  logic [IDX_W-1:0]      slot;

  logic [COUNT_BITS-1:0] cnt_cur;
  logic [COUNT_BITS-1:0] cnt_inc;

  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  logic [COUNT_BITS-1:0] mem_wdata;
  logic [IDX_W-1:0]      mem_raddr;
  logic [COUNT_BITS-1:0] rd_data_r;

  logic [IDX_W-1:0]      clr_cnt_r;
  logic [IDX_W:0]        walk_cnt_r;
  logic                  walk_issue;
  logic                  rd_vld_r;
  logic [IDX_W-1:0]      rd_idx_r;
  logic [CUM_W-1:0]      cum_r;
  logic [CUM_W-1:0]      walk_sum;
  logic                  walk_hit;
  logic [CUM_W-1:0]      tgt_r;
  logic [PROD_W-1:0]     prod_r;
  logic [PROD_W:0]       tsum;
  logic [CUM_W-1:0]      tgt_raw;
  logic [IDX_W-1:0]      found_r;
  logic [SAMPLE_W-1:0]   ans_r;

  logic [IDX_W-1:0]      top_off;
  logic [5:0]            top_sh;
  logic [SAMPLE_W-1:0]   top_base;
  logic [SAMPLE_W-1:0]   top_val;

  logic [CNT_OUT_W-1:0]  cnt_out;
  logic                  out_free;
  logic                  out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;

  assign in_sample = in_tdata[SAMPLE_W-1:0];
  assign in_frac   = in_tdata[SAMPLE_W +: FRAC_W];
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_free   = !out_tvalid_r || out_tready;

  // slot of the sample in stage A
  always_comb begin
    msb = '0;
    for (int i = 0; i < SAMPLE_W; i++) begin
      if (rec_a_val_r[i]) begin
        msb = 6'(i);
      end
    end
    oct     = 7'(msb) - 7'(SUB_BUCKET_BITS) + 7'd1;
    sh      = msb - 6'(SUB_BUCKET_BITS);
    shifted = rec_a_val_r >> sh;
    if ((rec_a_val_r >> SUB_BUCKET_BITS) == '0) begin
      slot = IDX_W'(rec_a_val_r[SUB_BUCKET_BITS-1:0]);
    end else if (oct > 7'(NUM_OCTAVES)) begin
      slot = IDX_LAST;
    end else begin
      slot = (IDX_W'(oct) << SUB_BUCKET_BITS) |
             IDX_W'(shifted[SUB_BUCKET_BITS-1:0]);
    end
  end

  // forward the previous write to the same bucket
  assign cnt_cur = (wl_vld_r && (wl_idx_r == rec_c_idx_r)) ? wl_val_r : rd_data_r;
  assign cnt_inc = (cnt_cur == CNT_MAX) ? cnt_cur : cnt_cur + 1'b1;

  assign mem_we    = (state_r == ST_CLEAR) || rec_c_vld_r;
  assign mem_waddr = (state_r == ST_CLEAR) ? clr_cnt_r : rec_c_idx_r;
  assign mem_wdata = (state_r == ST_CLEAR) ? '0 : cnt_inc;
  assign mem_raddr = (state_r == ST_WALK) ? walk_cnt_r[IDX_W-1:0] : rec_b_idx_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  assign walk_issue = (state_r == ST_WALK) && (walk_cnt_r < IDX_END);
  assign walk_sum   = cum_r + CUM_W'(rd_data_r);
  assign walk_hit   = walk_sum >= tgt_r;

  assign tsum    = (PROD_W + 1)'(prod_r) + (PROD_W + 1)'(16'hFFFF);
  assign tgt_raw = CUM_W'(tsum[PROD_W:16]);

  // upper bound of the found bucket
  always_comb begin
    top_off  = found_r - IDX_W'(SUB_COUNT);
    top_sh   = 6'(top_off >> SUB_BUCKET_BITS);
    top_base = SAMPLE_W'(top_off[SUB_BUCKET_BITS-1:0]) + SAMPLE_W'(SUB_COUNT) + 64'd1;
    if (found_r < IDX_W'(SUB_COUNT)) begin
      top_val = SAMPLE_W'(found_r);
    end else begin
      top_val = (top_base << top_sh) - 64'd1;
    end
  end

  assign cnt_out = (64'(total_r) > 64'hFFFF_FFFF) ? {CNT_OUT_W{1'b1}}
                                                  : CNT_OUT_W'(total_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == IDX_LAST) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc && (in_tuser[0] == CMD_QUERY)) state_nxt = ST_MUL;
      end
      ST_MUL:  state_nxt = ST_TGT;
      ST_TGT:  state_nxt = (total_r == '0) ? ST_DONE : ST_WALK;
      ST_WALK: begin
        if (rd_vld_r) begin
          if (walk_hit) begin
            state_nxt = ST_TOP;
          end else if (rd_idx_r == IDX_LAST) begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_TOP:  state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_cnt_r    <= '0;
      total_r      <= '0;
      largest_r    <= '0;
      rec_a_vld_r  <= 1'b0;
      rec_b_vld_r  <= 1'b0;
      rec_c_vld_r  <= 1'b0;
      wl_vld_r     <= 1'b0;
      rd_vld_r     <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rec_a_vld_r <= in_acc && (in_tuser[0] == CMD_RECORD);
      rec_b_vld_r <= rec_a_vld_r;
      rec_c_vld_r <= rec_b_vld_r;
      wl_vld_r    <= rec_c_vld_r;
      rd_vld_r    <= walk_issue;
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (in_acc && (in_tuser[0] == CMD_RECORD)) begin
        if (total_r != CNT_MAX) total_r <= total_r + 1'b1;
        if (in_sample > largest_r) largest_r <= in_sample;
      end
      if ((state_r == ST_DONE) && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rec_a_val_r <= in_sample;
    rec_b_idx_r <= slot;
    rec_c_idx_r <= rec_b_idx_r;
    wl_idx_r    <= rec_c_idx_r;
    wl_val_r    <= cnt_inc;
    rd_idx_r    <= mem_raddr;
    if (in_acc) begin
      frac_r <= (in_frac > Q16_ONE) ? Q16_ONE : in_frac;
    end
    case (state_r)
      ST_MUL: begin
        prod_r <= PROD_W'(frac_r) * PROD_W'(total_r);
      end
      ST_TGT: begin
        tgt_r      <= (tgt_raw == '0) ? CUM_W'(1) : tgt_raw;
        cum_r      <= '0;
        walk_cnt_r <= '0;
        ans_r      <= '0;
      end
      ST_WALK: begin
        if (walk_issue) walk_cnt_r <= walk_cnt_r + 1'b1;
        if (rd_vld_r) begin
          cum_r <= walk_sum;
          if (walk_hit) begin
            found_r <= rd_idx_r;
          end else begin
            ans_r <= largest_r;
          end
        end
      end
      ST_TOP: begin
        ans_r <= top_val;
      end
      ST_DONE: begin
        if (out_free) out_tdata_r <= {cnt_out, ans_r};
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire
